>>> sv/sls_pkg.sv
// ============================================================================
// sls_pkg
// Shared constants, field widths and control/status types of the segment
// label search block.
// ============================================================================
package sls_pkg;

    localparam int DEFAULT_STORE_DEPTH = 4096;

    localparam int CMD_W   = 2;
    localparam int ADDR_W  = 12;
    localparam int LABEL_W = 8;
    localparam int LEN_W   = 9;
    localparam int END_W   = 13;

    localparam int LANES     = 16;
    localparam int LANE_BITS = 4;
    localparam int ROW_W     = END_W - LANE_BITS;

    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EXACT   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GREATER = 2'd2;

    typedef struct packed {
        logic wr_en;
        logic load;
        logic scan_en;
        logic out_load;
    } sls_cmd_t;

    typedef struct packed {
        logic in_write;
        logic in_search;
        logic in_empty;
        logic scan_done;
    } sls_stat_t;

endpackage

>>> sv/segment_label_search.sv
// A search reads its segment's store rows (16 labels a row), one row a cycle, stopping at
// the first row with a hit; a 256-label segment spans at most 17 rows. An empty segment
// skips the scan. A new request is taken only once the result is in the output register.
// Writes are stored on acceptance. Reset clears the controller and output valid; the label
// store is not cleared and holds undefined labels until written.
// ============================================================================
// segment_label_search
// Byte label store with exact and first-greater search over a segment.
// ============================================================================
module segment_label_search #(
    parameter int STORE_DEPTH = sls_pkg::DEFAULT_STORE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // address[11:0], label_value[19:12], segment_length[28:20]
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // position[11:0]
    output logic        m_tuser    // found[0]
);

    sls_pkg::sls_cmd_t             cmd;
    sls_pkg::sls_stat_t            stat;
    logic [sls_pkg::ADDR_W-1:0]    position;

    sls_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sls_datapath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .in_command        (s_tuser),
        .in_address        (s_tdata[11:0]),
        .in_label_value    (s_tdata[19:12]),
        .in_segment_length (s_tdata[28:20]),
        .out_found         (m_tuser),
        .out_position      (position)
    );

    assign m_tdata = {4'b0, position};

endmodule

>>> sv/sls_datapath.sv
// ============================================================================
// sls_datapath
// Label store (rows of sixteen labels), row scan with lane compare and
// lowest-hit select, result and output registers.
// ============================================================================
module sls_datapath #(
    parameter int STORE_DEPTH = sls_pkg::DEFAULT_STORE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sls_pkg::sls_cmd_t              cmd,
    output sls_pkg::sls_stat_t             stat,
    input  logic [sls_pkg::CMD_W-1:0]      in_command,
    input  logic [sls_pkg::ADDR_W-1:0]     in_address,
    input  logic [sls_pkg::LABEL_W-1:0]    in_label_value,
    input  logic [sls_pkg::LEN_W-1:0]      in_segment_length,
    output logic                           out_found,
    output logic [sls_pkg::ADDR_W-1:0]     out_position
);

    localparam int ROWS   = (STORE_DEPTH + sls_pkg::LANES - 1) / sls_pkg::LANES;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int LW     = sls_pkg::LABEL_W;

    logic [sls_pkg::LANES*LW-1:0] mem [ROWS];

    logic                          exact_reg;
    logic [sls_pkg::ADDR_W-1:0]    start_reg;
    logic [LW-1:0]                 target_reg;
    logic [sls_pkg::END_W-1:0]     end_reg;
    logic [sls_pkg::ROW_W-1:0]     last_row_reg;
    logic [sls_pkg::ROW_W-1:0]     row_reg;
    logic [sls_pkg::ROW_W-1:0]     chk_row_reg;
    logic                          issued_all_reg;
    logic                          rd_valid_reg;
    logic [sls_pkg::LANES*LW-1:0]  rd_data_reg;
    logic                          res_found_reg;
    logic [sls_pkg::ADDR_W-1:0]    res_pos_reg;
    logic                          found_out_reg;
    logic [sls_pkg::ADDR_W-1:0]    pos_out_reg;

    logic [sls_pkg::END_W-1:0]     in_sum;
    logic [sls_pkg::END_W-1:0]     in_end;
    logic [sls_pkg::END_W-1:0]     in_end_m1;
    logic                          wr_in_range;
    logic [ROW_AW-1:0]             wr_row;
    logic [sls_pkg::LANE_BITS-1:0] wr_lane;
    logic [ROW_AW-1:0]             rd_row;
    logic                          issue;
    logic [sls_pkg::LANES-1:0]     lane_match;
    logic                          hit;
    logic [sls_pkg::LANE_BITS-1:0] hit_lane;

    // segment end, clamped at the store end
    always_comb
    begin
        in_sum    = {1'b0, in_address} + sls_pkg::END_W'(in_segment_length);
        in_end    = (32'(in_sum) > 32'(STORE_DEPTH)) ? sls_pkg::END_W'(STORE_DEPTH) : in_sum;
        in_end_m1 = in_end - sls_pkg::END_W'(1);
    end

    assign wr_in_range = 32'(in_address) < 32'(STORE_DEPTH);
    assign wr_row      = ROW_AW'(in_address[sls_pkg::ADDR_W-1:sls_pkg::LANE_BITS]);
    assign wr_lane     = in_address[sls_pkg::LANE_BITS-1:0];
    assign rd_row      = ROW_AW'(row_reg);
    assign issue       = cmd.scan_en && !issued_all_reg;

    assign stat.in_write  = in_command == sls_pkg::CMD_WRITE;
    assign stat.in_search = (in_command == sls_pkg::CMD_EXACT) ||
                            (in_command == sls_pkg::CMD_GREATER);
    assign stat.in_empty  = in_end <= {1'b0, in_address};
    assign stat.scan_done = rd_valid_reg && (hit || (chk_row_reg == last_row_reg));

    always_comb
    begin
        logic [LW-1:0]             lab;
        logic [sls_pkg::END_W-1:0] idx;
        for (int j = 0; j < sls_pkg::LANES; j++)
        begin
            lab = rd_data_reg[LW*j +: LW];
            idx = {chk_row_reg, sls_pkg::LANE_BITS'(j)};
            lane_match[j] = (exact_reg ? (lab == target_reg) : (lab > target_reg)) &&
                            (idx >= {1'b0, start_reg}) && (idx < end_reg);
        end
    end

    // lowest matching lane
    always_comb
    begin
        hit      = 1'b0;
        hit_lane = '0;
        for (int j = 0; j < sls_pkg::LANES; j++)
        begin
            if (!hit && lane_match[j])
            begin
                hit      = 1'b1;
                hit_lane = sls_pkg::LANE_BITS'(j);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && wr_in_range)
        begin
            mem[wr_row][LW*wr_lane +: LW] <= in_label_value;
        end
        if (issue)
        begin
            rd_data_reg <= mem[rd_row];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issued_all_reg <= 1'b1;
            rd_valid_reg   <= 1'b0;
        end
        else if (cmd.load)
        begin
            issued_all_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= issue;
            if (issue)
            begin
                issued_all_reg <= row_reg == last_row_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            exact_reg     <= in_command == sls_pkg::CMD_EXACT;
            start_reg     <= in_address;
            target_reg    <= in_label_value;
            end_reg       <= in_end;
            last_row_reg  <= in_end_m1[sls_pkg::END_W-1:sls_pkg::LANE_BITS];
            row_reg       <= sls_pkg::ROW_W'(in_address[sls_pkg::ADDR_W-1:sls_pkg::LANE_BITS]);
            res_found_reg <= 1'b0;
            res_pos_reg   <= in_address;
        end
        else
        begin
            if (issue)
            begin
                chk_row_reg <= row_reg;
                row_reg     <= row_reg + sls_pkg::ROW_W'(1);
            end
            if (cmd.scan_en && rd_valid_reg && hit)
            begin
                res_found_reg <= 1'b1;
                res_pos_reg   <= sls_pkg::ADDR_W'({chk_row_reg, hit_lane});
            end
        end
        if (cmd.out_load)
        begin
            found_out_reg <= res_found_reg;
            pos_out_reg   <= res_pos_reg;
        end
    end

    assign out_found    = found_out_reg;
    assign out_position = pos_out_reg;

endmodule

>>> sv/sls_controller.sv
// ============================================================================
// sls_controller
// Request sequencing: accept, row scan, result hand-off to the output
// register.
// ============================================================================
module sls_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  sls_pkg::sls_stat_t  stat,
    output sls_pkg::sls_cmd_t   cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;

    assign in_ready = state_reg == ST_IDLE;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next   = state_reg;
        cmd.wr_en    = 1'b0;
        cmd.load     = 1'b0;
        cmd.scan_en  = 1'b0;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.wr_en = stat.in_write;
                    cmd.load  = stat.in_search;
                    if (stat.in_search)
                    begin
                        state_next = stat.in_empty ? ST_DONE : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
